### src/tsp2o_pkg.sv
// Shared types and constants for the 2-opt route search block.
// Used by the route memory, the cost evaluator and the top level.
package tsp2o_pkg;

  localparam int MaxCities = 32;
  localparam int IdxBits   = 5;
  localparam int CntBits   = 6;
  localparam int DistBits  = 16;
  localparam int CostBits  = 22;
  localparam int ShowBits  = 21;

  localparam logic [1:0] CmdDist   = 2'd0;
  localparam logic [1:0] CmdRoute  = 2'd1;
  localparam logic [1:0] CmdRun    = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic RegCityCount = 1'b0;
  localparam logic RegPassLimit = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [15:0] distance;
    logic [4:0]  position;
    logic [4:0]  city;
  } in_t;

  typedef struct packed {
    logic [4:0]  out_position;
    logic [4:0]  out_city;
    logic [20:0] tour_cost;
    logic [15:0] passes_used;
    logic        last;
  } out_t;

  // Control from the sequencer to the cost evaluator
  typedef struct packed {
    logic               start;
    logic [IdxBits-1:0] i;
    logic [IdxBits-1:0] k;
    logic [CntBits-1:0] n;
  } ev_ctl_t;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StEval  = 9'b000000010,
    StCheck = 9'b000000100,
    StSwRd  = 9'b000001000,
    StSwWa  = 9'b000010000,
    StSwWb  = 9'b000100000,
    StOutRd = 9'b001000000,
    StOutLd = 9'b010000000,
    StOutWt = 9'b100000000
  } state_t;

endpackage

### src/tsp2o_route_ram.sv
// Route memory: one city index per position, two registered read ports, one write.
// Depends on tsp2o_pkg.
module tsp2o_route_ram (
  input  logic                          clk,
  input  logic [tsp2o_pkg::IdxBits-1:0] addr_a,
  input  logic [tsp2o_pkg::IdxBits-1:0] addr_b,
  input  logic                          we,
  input  logic [tsp2o_pkg::IdxBits-1:0] waddr,
  input  logic [tsp2o_pkg::IdxBits-1:0] wdata,
  output logic [tsp2o_pkg::IdxBits-1:0] q_a,
  output logic [tsp2o_pkg::IdxBits-1:0] q_b
);

  logic [tsp2o_pkg::IdxBits-1:0] mem [tsp2o_pkg::MaxCities];

  // Write one position, read two
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_a <= mem[addr_a];
    q_b <= mem[addr_b];
  end

endmodule

### src/tsp2o_cost_eval.sv
// Open-path cost of the route with positions i..k reversed; holds the distance memory.
// Streams one position per cycle through route read, distance read and accumulate.
// Depends on tsp2o_pkg.
module tsp2o_cost_eval (
  input  logic                           clk,
  input  logic                           rst,
  input  tsp2o_pkg::ev_ctl_t             ctl,
  input  logic                           dist_we,
  input  logic [2*tsp2o_pkg::IdxBits-1:0] dist_waddr,
  input  logic [tsp2o_pkg::DistBits-1:0] dist_wdata,
  output logic [tsp2o_pkg::IdxBits-1:0]  route_addr,
  input  logic [tsp2o_pkg::IdxBits-1:0]  route_q,
  output logic                           done,
  output logic [tsp2o_pkg::CostBits-1:0] cost
);

  logic [tsp2o_pkg::DistBits-1:0] mem [tsp2o_pkg::MaxCities*tsp2o_pkg::MaxCities];
  logic [tsp2o_pkg::DistBits-1:0] dist_q;
  logic [tsp2o_pkg::IdxBits-1:0]  from;
  logic [tsp2o_pkg::CntBits-1:0]  p;
  logic [tsp2o_pkg::CntBits-1:0]  mirror;
  logic busy, v1, v2, issuing, in_seg;

  assign issuing = busy && (p < ctl.n);
  assign in_seg  = (p[tsp2o_pkg::IdxBits-1:0] >= ctl.i) && (p[tsp2o_pkg::IdxBits-1:0] <= ctl.k);
  assign mirror  = {1'b0, ctl.i} + {1'b0, ctl.k} - p;
  assign route_addr = in_seg ? mirror[tsp2o_pkg::IdxBits-1:0] : p[tsp2o_pkg::IdxBits-1:0];

  // Distance memory: load port and lookup of (from, to)
  always_ff @(posedge clk) begin
    if (dist_we) begin
      mem[dist_waddr] <= dist_wdata;
    end
    dist_q <= mem[{from, route_q}];
  end

  // Advance position counter and pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
      p    <= '0;
    end else begin
      done <= 1'b0;
      v1   <= issuing;
      v2   <= v1;
      if (ctl.start) begin
        busy <= 1'b1;
        p    <= '0;
      end else if (issuing) begin
        p <= p + 1'b1;
      end else if (busy && !v1 && !v2) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Track previous city and accumulate the sum
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      from <= '0;
      cost <= '0;
    end else begin
      if (v1) begin
        from <= route_q;
      end
      if (v2) begin
        cost <= cost + {{(tsp2o_pkg::CostBits-tsp2o_pkg::DistBits){1'b0}}, dist_q};
      end
    end
  end

endmodule

### src/tsp_two_opt_local_search_top.sv
// Top level of the 2-opt open-path route search: request decode, pass sequencer,
// segment reversal and result stream. Depends on tsp2o_pkg, tsp2o_route_ram, tsp2o_cost_eval.
//
// Usage. Requests arrive on in_valid/in_stall/in_data. A distance write or a route
// write is accepted while idle. A run request evaluates every reversal i..k of the
// stored route, takes the first strictly cheaper one for each i, and repeats passes
// until one improves nothing or pass_limit passes have run. Each reversal is
// evaluated with one route read and one distance read per position, one position
// per cycle; an accepted one is then swapped pair by pair in the route memory (read,
// write a, write b). The route then streams out on out_valid/out_stall/out_data, one
// position at a time, the next only after the last is taken, with last set on
// position n-1. in_stall is high from the run request until the last result is taken;
// a stalled result holds its register. cfg_we/cfg_index/cfg_data write city_count and
// pass_limit; the user must write them only while idle, which the block does not enforce.
// Reset (rst, synchronous) clears control state and sets city_count to 32 and
// pass_limit to 1000; memory contents are undefined until written.
module tsp_two_opt_local_search_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  tsp2o_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output tsp2o_pkg::out_t  out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_data
);

  localparam int IW = tsp2o_pkg::IdxBits;
  localparam int CW = tsp2o_pkg::CntBits;

  tsp2o_pkg::state_t state;
  tsp2o_pkg::ev_ctl_t ctl;

  logic [CW-1:0] city_count;
  logic [15:0]   pass_limit;
  logic [CW-1:0] n;
  logic [IW-1:0] i, k, a, b, op, qa_hold;
  logic [15:0]   pass_counter;
  logic [tsp2o_pkg::CostBits-1:0] best_cost;
  logic          improved_flag, init_run, ev_start;

  logic [IW-1:0] addr_a, addr_b, waddr, wdata, q_a, q_b, ev_addr;
  logic          we, ev_done, accept;
  logic [tsp2o_pkg::CostBits-1:0] ev_cost;
  logic [CW-1:0] i_inc;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != tsp2o_pkg::StIdle);
  assign i_inc    = {1'b0, i} + 1'b1;

  assign ctl.start = ev_start;
  assign ctl.i     = i;
  assign ctl.k     = k;
  assign ctl.n     = n;

  // Route memory port selection
  always_comb begin
    addr_a = ev_addr;
    addr_b = b;
    we     = 1'b0;
    waddr  = in_data.position;
    wdata  = in_data.city;
    case (state)
      tsp2o_pkg::StIdle: begin
        we = accept && (in_data.cmd == tsp2o_pkg::CmdRoute);
      end
      tsp2o_pkg::StSwRd: begin
        addr_a = a;
      end
      tsp2o_pkg::StSwWa: begin
        we    = 1'b1;
        waddr = a;
        wdata = q_b;
      end
      tsp2o_pkg::StSwWb: begin
        we    = 1'b1;
        waddr = b;
        wdata = qa_hold;
      end
      tsp2o_pkg::StOutRd: begin
        addr_a = op;
      end
      default: begin
        addr_a = ev_addr;
      end
    endcase
  end

  tsp2o_route_ram u_route (
    .clk    (clk),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .q_a    (q_a),
    .q_b    (q_b)
  );

  tsp2o_cost_eval u_eval (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .dist_we    (accept && (in_data.cmd == tsp2o_pkg::CmdDist)),
    .dist_waddr ({in_data.row, in_data.col}),
    .dist_wdata (in_data.distance),
    .route_addr (ev_addr),
    .route_q    (q_a),
    .done       (ev_done),
    .cost       (ev_cost)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= CW'(32);
      pass_limit <= 16'd1000;
    end else if (cfg_we) begin
      if (cfg_index == tsp2o_pkg::RegCityCount) begin
        city_count <= cfg_data[CW-1:0];
      end else begin
        pass_limit <= cfg_data;
      end
    end
  end

  // Sequencer: passes, reversal tries, segment swaps and result stream
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tsp2o_pkg::StIdle;
      ev_start      <= 1'b0;
      out_valid     <= 1'b0;
      improved_flag <= 1'b0;
      pass_counter  <= '0;
      best_cost     <= '0;
      init_run      <= 1'b0;
      n             <= CW'(2);
      i             <= '0;
      k             <= '0;
      a             <= '0;
      b             <= '0;
      op            <= '0;
    end else begin
      ev_start <= 1'b0;
      case (state)
        tsp2o_pkg::StIdle: begin
          if (accept && (in_data.cmd == tsp2o_pkg::CmdRun)) begin
            if (city_count < CW'(2)) begin
              n <= CW'(2);
            end else if (city_count > CW'(tsp2o_pkg::MaxCities)) begin
              n <= CW'(tsp2o_pkg::MaxCities);
            end else begin
              n <= city_count;
            end
            pass_counter <= '0;
            i            <= '0;
            k            <= '0;
            init_run     <= 1'b1;
            ev_start     <= 1'b1;
            state        <= tsp2o_pkg::StEval;
          end
        end
        tsp2o_pkg::StEval: begin
          if (ev_done) begin
            if (init_run) begin
              init_run      <= 1'b0;
              best_cost     <= ev_cost;
              improved_flag <= 1'b1;
              state         <= tsp2o_pkg::StCheck;
            end else if (ev_cost < best_cost) begin
              best_cost     <= ev_cost;
              improved_flag <= 1'b1;
              a             <= i;
              b             <= k;
              state         <= tsp2o_pkg::StSwRd;
            end else if ({1'b0, k} + 1'b1 < n) begin
              k        <= k + 1'b1;
              ev_start <= 1'b1;
            end else if (i_inc + 1'b1 < n) begin
              i        <= i_inc[IW-1:0];
              k        <= i_inc[IW-1:0] + 1'b1;
              ev_start <= 1'b1;
            end else begin
              pass_counter <= pass_counter + 1'b1;
              state        <= tsp2o_pkg::StCheck;
            end
          end
        end
        tsp2o_pkg::StCheck: begin
          if (improved_flag && (pass_counter < pass_limit)) begin
            improved_flag <= 1'b0;
            i             <= '0;
            k             <= IW'(1);
            ev_start      <= 1'b1;
            state         <= tsp2o_pkg::StEval;
          end else begin
            op    <= '0;
            state <= tsp2o_pkg::StOutRd;
          end
        end
        tsp2o_pkg::StSwRd: begin
          state <= tsp2o_pkg::StSwWa;
        end
        tsp2o_pkg::StSwWa: begin
          qa_hold <= q_a;
          state   <= tsp2o_pkg::StSwWb;
        end
        tsp2o_pkg::StSwWb: begin
          if ({1'b0, a} + CW'(2) < {1'b0, b}) begin
            a     <= a + 1'b1;
            b     <= b - 1'b1;
            state <= tsp2o_pkg::StSwRd;
          end else if (i_inc + 1'b1 < n) begin
            i        <= i_inc[IW-1:0];
            k        <= i_inc[IW-1:0] + 1'b1;
            ev_start <= 1'b1;
            state    <= tsp2o_pkg::StEval;
          end else begin
            pass_counter <= pass_counter + 1'b1;
            state        <= tsp2o_pkg::StCheck;
          end
        end
        tsp2o_pkg::StOutRd: begin
          state <= tsp2o_pkg::StOutLd;
        end
        tsp2o_pkg::StOutLd: begin
          out_valid             <= 1'b1;
          out_data.out_position <= op;
          out_data.out_city     <= q_a;
          out_data.tour_cost    <= best_cost[tsp2o_pkg::CostBits-1]
                                   ? {tsp2o_pkg::ShowBits{1'b1}}
                                   : best_cost[tsp2o_pkg::ShowBits-1:0];
          out_data.passes_used  <= pass_counter;
          out_data.last         <= ({1'b0, op} + 1'b1 == n);
          state                 <= tsp2o_pkg::StOutWt;
        end
        tsp2o_pkg::StOutWt: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (out_data.last) begin
              state <= tsp2o_pkg::StIdle;
            end else begin
              op    <= op + 1'b1;
              state <= tsp2o_pkg::StOutRd;
            end
          end
        end
        default: begin
          state <= tsp2o_pkg::StIdle;
        end
      endcase
    end
  end

endmodule
